// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication or invariant, checked outside reset.
`define ASSERT_CLKD(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tbsd_pkg.sv =====
`default_nettype none

package tbsd_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned CodeW  = 16;
    localparam int unsigned ModeW  = 2;
    localparam int unsigned PendW  = 2;

    // decode_mode register codes; the unused code decodes as UTF-8
    localparam logic [ModeW-1:0] MODE_U16_HI = 2'd0;
    localparam logic [ModeW-1:0] MODE_U16_LO = 2'd1;
    localparam logic [ModeW-1:0] MODE_UTF8   = 2'd2;
    localparam logic [ModeW-1:0] MODE_RESET  = MODE_UTF8;

    localparam logic [CodeW-1:0] CP_BAD = 16'hFEFF;

    // UTF-8 lead byte boundaries
    localparam logic [ByteW-1:0] LEAD_CONT  = 8'h80;
    localparam logic [ByteW-1:0] LEAD_TWO   = 8'hC0;
    localparam logic [ByteW-1:0] LEAD_THREE = 8'hE0;
    localparam logic [ByteW-1:0] LEAD_BAD   = 8'hF0;

    typedef struct packed {
        logic [ByteW-1:0] data_byte;
        logic             stream_end;
    } item_t;

    typedef struct packed {
        logic             valid;
        logic [CodeW-1:0] code_point;
        logic             end_of_text;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/tbsd_dec.sv =====
`default_nettype none
`include "assert_macros.svh"

module tbsd_dec (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [tbsd_pkg::ModeW-1:0]    cfg_wdata,
    input  wire logic                          step_en,
    input  wire tbsd_pkg::item_t               item,
    output tbsd_pkg::result_t                  result
);

    logic [tbsd_pkg::ModeW-1:0] mode_reg, mode_next;
    logic [tbsd_pkg::PendW-1:0] pend_reg, pend_next;
    logic [tbsd_pkg::CodeW-1:0] part_reg, part_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= tbsd_pkg::MODE_RESET;
            pend_reg <= '0;
            part_reg <= '0;
        end else begin
            mode_reg <= mode_next;
            pend_reg <= pend_next;
            part_reg <= part_next;
        end
    end

    always_comb begin
        logic [tbsd_pkg::ByteW-1:0] b;
        b         = item.data_byte;
        mode_next = mode_reg;
        pend_next = pend_reg;
        part_next = part_reg;
        result    = '0;
        if (cfg_we) begin
            // new mode drops any partial sequence
            mode_next = cfg_wdata;
            pend_next = '0;
            part_next = '0;
        end else if (step_en) begin
            if (item.stream_end) begin
                pend_next          = '0;
                part_next          = '0;
                result.valid       = 1'b1;
                result.end_of_text = 1'b1;
            end else begin
                case (mode_reg) inside
                    tbsd_pkg::MODE_U16_HI, tbsd_pkg::MODE_U16_LO: begin
                        if (pend_reg == '0) begin
                            part_next = {8'h00, b};
                            pend_next = 2'd1;
                        end else begin
                            result.valid = 1'b1;
                            if (mode_reg == tbsd_pkg::MODE_U16_HI) begin
                                result.code_point = {part_reg[7:0], b};
                            end else begin
                                result.code_point = {b, part_reg[7:0]};
                            end
                            pend_next = '0;
                            part_next = '0;
                        end
                    end
                    default: begin
                        if (pend_reg == '0) begin
                            if (b < tbsd_pkg::LEAD_CONT) begin
                                result.valid      = 1'b1;
                                result.code_point = {8'h00, b};
                            end else if (b < tbsd_pkg::LEAD_TWO) begin
                                result.valid      = 1'b1;
                                result.code_point = tbsd_pkg::CP_BAD;
                            end else if (b < tbsd_pkg::LEAD_THREE) begin
                                part_next = {5'b0, b[4:0], 6'b0};
                                pend_next = 2'd1;
                            end else if (b < tbsd_pkg::LEAD_BAD) begin
                                part_next = {b[3:0], 12'b0};
                                pend_next = 2'd2;
                            end else begin
                                result.valid      = 1'b1;
                                result.code_point = tbsd_pkg::CP_BAD;
                            end
                        end else if (pend_reg >= 2'd2) begin
                            // continuation bytes are taken unchecked
                            part_next = part_reg | {4'b0, b[5:0], 6'b0};
                            pend_next = 2'd1;
                        end else begin
                            result.valid      = 1'b1;
                            result.code_point = part_reg | {10'b0, b[5:0]};
                            pend_next         = '0;
                            part_next         = '0;
                        end
                    end
                endcase
            end
        end
    end

    `ASSERT_NEXT(a_end_clears, aclk, aresetn, step_en && item.stream_end && !cfg_we, pend_reg == '0 && part_reg == '0, "end mark left a partial sequence")
    `ASSERT_NEXT(a_cfg_loads, aclk, aresetn, cfg_we, pend_reg == '0 && mode_reg == $past(cfg_wdata), "mode write did not take or clear")
    `ASSERT_CLKD(a_u16_pend, aclk, aresetn, (mode_reg == tbsd_pkg::MODE_U16_HI || mode_reg == tbsd_pkg::MODE_U16_LO) |-> pend_reg <= 2'd1, "UTF-16 waits on more than one byte")

endmodule

`default_nettype wire

// ===== sv/text_byte_stream_decoder_top.sv =====
// Channel  Dir  tdata                 tlast        tuser
// s_       in   [7:0] data_byte       stream_end   -
// m_       out  [15:0] code_point     end_of_text  -
// cfg_     in   [1:0] decode_mode     -            -
//
// One input transaction is taken per cycle while s_tready is high; each byte lands in
// the input register and is decoded into the result register once that is free, so
// a result passes through both registers; a byte that ends no character gives none.
// The decode state sits in a single register set updated per item and per mode write.
// aresetn is synchronous, active low; it restores UTF-8 mode and empties both stages.
// A stall on m_ holds the result register and, through s_tready, the input register.
`default_nettype none
`include "assert_macros.svh"

module text_byte_stream_decoder_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [tbsd_pkg::ModeW-1:0]    cfg_wdata,    // decode_mode
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [tbsd_pkg::ByteW-1:0]    s_tdata,      // [7:0] data_byte
    input  wire logic                          s_tlast,      // stream_end
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [tbsd_pkg::CodeW-1:0]         m_tdata,      // [15:0] code_point
    output logic                               m_tlast       // end_of_text
);

    logic                       in_valid_reg;
    tbsd_pkg::item_t            in_item_reg;
    logic                       out_valid_reg;
    logic [tbsd_pkg::CodeW-1:0] out_cp_reg;
    logic                       out_end_reg;

    logic              out_free;
    logic              step_en;
    tbsd_pkg::result_t result;

    // result register can take a new value when empty or being drained
    assign out_free = !out_valid_reg || m_tready;
    // advance the held item only when its result has a place to go
    assign step_en  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.data_byte  <= s_tdata;
            in_item_reg.stream_end <= s_tlast;
        end
    end

    tbsd_dec u_dec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .step_en   (step_en),
        .item      (in_item_reg),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= result.valid;
        end
    end

    // hold payload unless a fresh result is loaded
    always_ff @(posedge aclk) begin
        if (out_free && result.valid) begin
            out_cp_reg  <= result.code_point;
            out_end_reg <= result.end_of_text;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_cp_reg;
    assign m_tlast  = out_end_reg;

    `ASSERT_CLKD(a_end_zero, aclk, aresetn, m_tvalid && m_tlast |-> m_tdata == '0, "end transaction carries a code point")
    `ASSERT_NEXT(a_stall_hold, aclk, aresetn, in_valid_reg && !out_free, in_valid_reg && $stable(in_item_reg), "held item lost during stall")

endmodule

`default_nettype wire
